// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file vn_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable
`define VN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property checked during reset too
`define VN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg
// shared types and constants for the 4d vector normalizer
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int COMP_WIDTH    = 16;
    localparam int UNIT_WIDTH    = 16;
    localparam int LANES         = 4;
    localparam int FRAC_SHIFT    = 32;
    localparam int Q_WIDTH       = 17;
    localparam int SEARCH_STAGES = Q_WIDTH;
    localparam int FRONT_STAGES  = 3;
    localparam int LATENCY       = FRONT_STAGES + SEARCH_STAGES + 1;
    localparam int SQ_WIDTH      = 2 * COMP_WIDTH;
    localparam int SUM_WIDTH     = SQ_WIDTH + 2;
    localparam int RES_WIDTH     = SQ_WIDTH + FRAC_SHIFT + 6;

    localparam logic [UNIT_WIDTH-1:0] UNIT_MAX = {1'b0, {(UNIT_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] comp_x;
        logic signed [COMP_WIDTH-1:0] comp_y;
        logic signed [COMP_WIDTH-1:0] comp_z;
        logic signed [COMP_WIDTH-1:0] comp_w;
    } vec_in_t;

    typedef struct packed {
        logic signed [UNIT_WIDTH-1:0] unit_x;
        logic signed [UNIT_WIDTH-1:0] unit_y;
        logic signed [UNIT_WIDTH-1:0] unit_z;
        logic signed [UNIT_WIDTH-1:0] unit_w;
        logic                         zero_length;
    } vec_out_t;

endpackage

// ===== rtl/core/vec4_normalize_top.sv =====
// ----------------------------------------------------------------------------
// vec4_normalize_top
// 4d vector normalization to q1.15, one vector per cycle
//
//   channel  | handshake    | payload
//   ---------+--------------+------------------
//   input    | start, busy  | operand (vec_in_t)
//   output   | done         | result (vec_out_t)
//
// a transfer may start every cycle; busy stays low
// done follows the accepting edge through 3 front, 17 lane search and 1 merge stages
// most of the latency comes from the bit per stage square root search in each lane
// reset clears the valid pipeline only; results cannot be stalled
// ----------------------------------------------------------------------------
module vec4_normalize_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  vn_pkg::vec_in_t  operand,
    output logic             done,
    output vn_pkg::vec_out_t result
);

    localparam int NS = vn_pkg::SEARCH_STAGES;

    logic [vn_pkg::SQ_WIDTH-1:0]  sq  [vn_pkg::LANES];
    logic [vn_pkg::SUM_WIDTH-1:0] sum;
    logic [vn_pkg::LANES-1:0]     neg;
    logic [vn_pkg::Q_WIDTH-1:0]   q   [vn_pkg::LANES];
    logic [vn_pkg::LANES-1:0]     neg_reg  [NS];
    logic [NS-1:0]                zero_reg;
    logic [vn_pkg::LATENCY-1:0]   valid_reg;
    logic [vn_pkg::LATENCY-1:0]   valid_next;

    assign busy = 1'b0;

    vn_sumsq u_sumsq (
        .clk     (clk),
        .operand (operand),
        .sq      (sq),
        .sum     (sum),
        .neg     (neg)
    );

    genvar l;
    generate
        for (l = 0; l < vn_pkg::LANES; l++)
        begin : g_lane
            vn_lane u_lane (
                .clk (clk),
                .sq  (sq[l]),
                .sum (sum),
                .q   (q[l])
            );
        end
    endgenerate

    // side band aligned with the lane search
    always_ff @(posedge clk)
    begin
        neg_reg[0]  <= neg;
        zero_reg[0] <= (sum == '0);
        for (int i = 1; i < NS; i++)
        begin
            neg_reg[i]  <= neg_reg[i-1];
            zero_reg[i] <= zero_reg[i-1];
        end
    end

    vn_merge u_merge (
        .clk    (clk),
        .q      (q),
        .neg    (neg_reg[NS-1]),
        .zero   (zero_reg[NS-1]),
        .result (result)
    );

    assign valid_next = {valid_reg[vn_pkg::LATENCY-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign done = valid_reg[vn_pkg::LATENCY-1];

endmodule

// ===== rtl/core/vn_sumsq.sv =====
// ----------------------------------------------------------------------------
// vn_sumsq
// magnitudes, squares and squared length, three register stages
// ----------------------------------------------------------------------------
module vn_sumsq (
    input  logic                                   clk,
    input  vn_pkg::vec_in_t                        operand,
    output logic [vn_pkg::SQ_WIDTH-1:0]            sq   [vn_pkg::LANES],
    output logic [vn_pkg::SUM_WIDTH-1:0]           sum,
    output logic [vn_pkg::LANES-1:0]               neg
);

    logic [vn_pkg::COMP_WIDTH-1:0] raw      [vn_pkg::LANES];
    logic [vn_pkg::COMP_WIDTH-1:0] mag_reg  [vn_pkg::LANES];
    logic [vn_pkg::SQ_WIDTH-1:0]   sq1_reg  [vn_pkg::LANES];
    logic [vn_pkg::SQ_WIDTH-1:0]   sq2_reg  [vn_pkg::LANES];
    logic [vn_pkg::SUM_WIDTH-1:0]  sum_reg;
    logic [vn_pkg::LANES-1:0]      neg1_reg;
    logic [vn_pkg::LANES-1:0]      neg2_reg;
    logic [vn_pkg::LANES-1:0]      neg3_reg;

    assign raw[0] = operand.comp_x;
    assign raw[1] = operand.comp_y;
    assign raw[2] = operand.comp_z;
    assign raw[3] = operand.comp_w;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < vn_pkg::LANES; i++)
        begin
            neg1_reg[i] <= raw[i][vn_pkg::COMP_WIDTH-1];
            mag_reg[i]  <= raw[i][vn_pkg::COMP_WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
            sq1_reg[i]  <= vn_pkg::SQ_WIDTH'(mag_reg[i]) * vn_pkg::SQ_WIDTH'(mag_reg[i]);
            sq2_reg[i]  <= sq1_reg[i];
        end
        neg2_reg <= neg1_reg;
        neg3_reg <= neg2_reg;
        sum_reg  <= vn_pkg::SUM_WIDTH'(sq1_reg[0]) + vn_pkg::SUM_WIDTH'(sq1_reg[1])
                  + vn_pkg::SUM_WIDTH'(sq1_reg[2]) + vn_pkg::SUM_WIDTH'(sq1_reg[3]);
    end

    assign sq  = sq2_reg;
    assign sum = sum_reg;
    assign neg = neg3_reg;

endmodule

// ===== rtl/core/vn_lane.sv =====
// ----------------------------------------------------------------------------
// vn_lane
// one bit per stage search of floor(sqrt(sq * 2^32 / sum))
// ----------------------------------------------------------------------------
module vn_lane (
    input  logic                              clk,
    input  logic [vn_pkg::SQ_WIDTH-1:0]       sq,
    input  logic [vn_pkg::SUM_WIDTH-1:0]      sum,
    output logic [vn_pkg::Q_WIDTH-1:0]        q
);

    localparam int W  = vn_pkg::RES_WIDTH;
    localparam int NS = vn_pkg::SEARCH_STAGES;

    // residual, running q * sum, sum, partial q
    logic [W-1:0]              r_reg [NS];
    logic [W-1:0]              p_reg [NS];
    logic [W-1:0]              s_reg [NS];
    logic [vn_pkg::Q_WIDTH-1:0] q_reg [NS];

    genvar i;
    generate
        for (i = 0; i < NS; i++)
        begin : g_stage
            localparam int B = NS - 1 - i;
            logic [W-1:0]              r_in;
            logic [W-1:0]              p_in;
            logic [W-1:0]              s_in;
            logic [vn_pkg::Q_WIDTH-1:0] q_in;
            logic [W-1:0]              term;
            logic [W:0]                cand;

            if (i == 0)
            begin : g_first
                assign r_in = W'(sq) << vn_pkg::FRAC_SHIFT;
                assign p_in = '0;
                assign s_in = W'(sum);
                assign q_in = '0;
            end
            else
            begin : g_next
                assign r_in = r_reg[i-1];
                assign p_in = p_reg[i-1];
                assign s_in = s_reg[i-1];
                assign q_in = q_reg[i-1];
            end

            assign term = (p_in << (B + 1)) + (s_in << (2 * B));
            assign cand = {1'b0, r_in} - {1'b0, term};

            always_ff @(posedge clk)
            begin
                s_reg[i] <= s_in;
                if (!cand[W])
                begin
                    r_reg[i] <= cand[W-1:0];
                    p_reg[i] <= p_in + (s_in << B);
                    q_reg[i] <= q_in | (vn_pkg::Q_WIDTH'(1) << B);
                end
                else
                begin
                    r_reg[i] <= r_in;
                    p_reg[i] <= p_in;
                    q_reg[i] <= q_in;
                end
            end
        end
    endgenerate

    assign q = q_reg[NS-1];

endmodule

// ===== rtl/core/vn_merge.sv =====
// ----------------------------------------------------------------------------
// vn_merge
// rounds lane results, applies sign, saturation and zero vector rule
// ----------------------------------------------------------------------------
module vn_merge (
    input  logic                          clk,
    input  logic [vn_pkg::Q_WIDTH-1:0]    q    [vn_pkg::LANES],
    input  logic [vn_pkg::LANES-1:0]      neg,
    input  logic                          zero,
    output vn_pkg::vec_out_t              result
);

    logic [vn_pkg::Q_WIDTH-1:0]    n    [vn_pkg::LANES];
    logic [vn_pkg::UNIT_WIDTH-1:0] unit [vn_pkg::LANES];
    vn_pkg::vec_out_t              result_reg;

    always_comb
    begin
        for (int i = 0; i < vn_pkg::LANES; i++)
        begin
            n[i] = vn_pkg::Q_WIDTH'((vn_pkg::Q_WIDTH + 1)'(q[i]) + 1'b1 >> 1);
            if (zero)
                unit[i] = '0;
            else if (neg[i])
                unit[i] = ~n[i][vn_pkg::UNIT_WIDTH-1:0] + 1'b1;
            else if (n[i] > vn_pkg::Q_WIDTH'(vn_pkg::UNIT_MAX))
                unit[i] = vn_pkg::UNIT_MAX;
            else
                unit[i] = n[i][vn_pkg::UNIT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.unit_x      <= unit[0];
        result_reg.unit_y      <= unit[1];
        result_reg.unit_z      <= unit[2];
        result_reg.unit_w      <= unit[3];
        result_reg.zero_length <= zero;
    end

    assign result = result_reg;

endmodule

// ===== rtl/core/vn_checker.sv =====
// ----------------------------------------------------------------------------
// vn_checker
// port level checks for the vector normalizer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vn_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  vn_pkg::vec_in_t  operand,
    input  logic             done,
    input  vn_pkg::vec_out_t result
);

    `VN_ASSERT(a_never_busy, !busy, "busy raised")
    `VN_ASSERT(a_done_has_start, done |-> $past(start && !busy, vn_pkg::LATENCY), "done without transfer")
    `VN_ASSERT(a_zero_vector, (start && !busy && operand == '0) |-> ##(vn_pkg::LATENCY) (done && result.zero_length), "zero vector not flagged")
    `VN_ASSERT(a_zero_outputs, (done && result.zero_length) |-> (result.unit_x == '0 && result.unit_y == '0 && result.unit_z == '0 && result.unit_w == '0), "zero vector with nonzero units")
    `VN_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !done, "done during reset")

endmodule

bind vec4_normalize_top vn_checker u_vn_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .operand (operand),
    .done    (done),
    .result  (result)
);
